// ----- src/tfn_pkg.sv -----
// tfn_pkg: widths and shared types for the triangle face normal pipeline.
// No dependencies; imported by the interfaces and every module.
package tfn_pkg;

   // Vertex coordinate width (two's complement) and normal fraction bits
   localparam int COORD_WIDTH      = 24;
   localparam int NORMAL_FRAC_BITS = 14;

   // Internal unit vector fraction bits and block alignment target bit
   localparam int UNIT_FRAC_BITS = 30;
   localparam int ALIGN_LO       = 29;

   localparam int EDGE_W = COORD_WIDTH + 1;    // edge difference
   localparam int VEC_W  = 64;                 // generic vector component
   localparam int POS_W  = 6;                  // bit position in VEC_W
   localparam int MAG_W  = ALIGN_LO + 1;       // aligned magnitude
   localparam int SQ_W   = 2 * MAG_W;          // one square
   localparam int SUM_W  = SQ_W + 2;           // sum of three squares
   localparam int ROOT_W = SUM_W / 2;          // floor square root
   localparam int REM_W  = ROOT_W + 3;         // root remainder
   localparam int QUOT_W = UNIT_FRAC_BITS + 1; // quotient, at most 2^bits
   localparam int DIV_W  = MAG_W + UNIT_FRAC_BITS + 1; // dividend
   localparam int COMP_W = QUOT_W + 1;         // signed unit component
   localparam int OUT_W  = 16;                 // result field width

   typedef logic [2:0][VEC_W-1:0]  vec_type;
   typedef logic [2:0][COMP_W-1:0] unit_vec_type;
   typedef logic [2:0][QUOT_W-1:0] quot_vec_type;

   // Sideband that travels with an item through root and divide stages
   typedef struct packed {
      logic                  tag;
      logic                  zero;
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
   } tfn_side_type;

endpackage

// ----- src/tfn_if.sv -----
// tfn_req_if / tfn_rsp_if: valid/ready channels for triangles and normals.
// Depends on tfn_pkg.
interface tfn_req_if import tfn_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_x;
   logic signed [COORD_WIDTH-1:0] first_y;
   logic signed [COORD_WIDTH-1:0] first_z;
   logic signed [COORD_WIDTH-1:0] second_x;
   logic signed [COORD_WIDTH-1:0] second_y;
   logic signed [COORD_WIDTH-1:0] second_z;
   logic signed [COORD_WIDTH-1:0] third_x;
   logic signed [COORD_WIDTH-1:0] third_y;
   logic signed [COORD_WIDTH-1:0] third_z;

   modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                   second_z, third_x, third_y, third_z, input ready);
   modport sink   (input valid, first_x, first_y, first_z, second_x, second_y,
                   second_z, third_x, third_y, third_z, output ready);
endinterface

interface tfn_rsp_if import tfn_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] normal_x;
   logic signed [OUT_W-1:0] normal_y;
   logic signed [OUT_W-1:0] normal_z;
   logic                    degenerate;

   modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                   input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, degenerate,
                   output ready);
endinterface

// ----- src/tfn_isqrt.sv -----
// tfn_isqrt: pipelined floor square root, one root bit per stage.
// Depends on tfn_pkg; carries the item sideband alongside.
module tfn_isqrt import tfn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [SUM_W-1:0]  in_sum,
   input  tfn_side_type      in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output tfn_side_type      out_side
);

   logic              st_valid [0:ROOT_W];
   logic [REM_W-1:0]  st_rem   [0:ROOT_W];
   logic [ROOT_W-1:0] st_root  [0:ROOT_W];
   logic [SUM_W-1:0]  st_x     [0:ROOT_W];
   tfn_side_type      st_side  [0:ROOT_W];

   assign st_valid[0] = in_valid;
   assign st_rem[0]   = '0;
   assign st_root[0]  = '0;
   assign st_x[0]     = in_sum;
   assign st_side[0]  = in_side;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              take;
      logic              valid_ff;
      logic [REM_W-1:0]  rem_ff,  rem_in;
      logic [ROOT_W-1:0] root_ff, root_in;
      logic [SUM_W-1:0]  x_ff,    x_in;
      tfn_side_type      side_ff;

      // bring down the next two radicand bits and try root*4+1
      always_comb begin
         rem_sh  = {st_rem[k][REM_W-3:0], st_x[k][SUM_W-1 -: 2]};
         trial   = REM_W'({st_root[k], 2'b01});
         take    = (rem_sh >= trial);
         rem_in  = take ? (rem_sh - trial) : rem_sh;
         root_in = {st_root[k][ROOT_W-2:0], take};
         x_in    = st_x[k] << 2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= st_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            x_ff    <= x_in;
            side_ff <= st_side[k];
         end
      end

      assign st_valid[k+1] = valid_ff;
      assign st_rem[k+1]   = rem_ff;
      assign st_root[k+1]  = root_ff;
      assign st_x[k+1]     = x_ff;
      assign st_side[k+1]  = side_ff;
   end

   assign out_valid = st_valid[ROOT_W];
   assign out_root  = st_root[ROOT_W];
   assign out_side  = st_side[ROOT_W];

endmodule

// ----- src/tfn_div.sv -----
// tfn_div: three-lane pipelined rounded division mag*2^bits/root,
// one quotient bit per stage. Depends on tfn_pkg.
module tfn_div import tfn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              narrow,
   input  logic              in_valid,
   input  logic [ROOT_W-1:0] in_root,
   input  tfn_side_type      in_side,
   output logic              out_valid,
   output quot_vec_type      out_quot,
   output tfn_side_type      out_side
);

   typedef logic [2:0][DIV_W-1:0] rem_vec_type;

   // dividend forming stage
   logic              form_valid_ff;
   rem_vec_type       form_rem_ff, form_rem_in;
   logic [ROOT_W-1:0] form_n_ff;
   tfn_side_type      form_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (narrow) begin
            form_rem_in[i] = (DIV_W'(in_side.mag[i]) << NORMAL_FRAC_BITS)
                             + DIV_W'(in_root >> 1);
         end else begin
            form_rem_in[i] = (DIV_W'(in_side.mag[i]) << UNIT_FRAC_BITS)
                             + DIV_W'(in_root >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         form_valid_ff <= 1'b0;
      end else if (en) begin
         form_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         form_rem_ff  <= form_rem_in;
         form_n_ff    <= in_root;
         form_side_ff <= in_side;
      end
   end

   logic              st_valid [0:QUOT_W];
   rem_vec_type       st_rem   [0:QUOT_W];
   quot_vec_type      st_q     [0:QUOT_W];
   logic [ROOT_W-1:0] st_n     [0:QUOT_W];
   tfn_side_type      st_side  [0:QUOT_W];

   assign st_valid[0] = form_valid_ff;
   assign st_rem[0]   = form_rem_ff;
   assign st_q[0]     = '0;
   assign st_n[0]     = form_n_ff;
   assign st_side[0]  = form_side_ff;

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      localparam int BIT = QUOT_W - 1 - k;
      logic [DIV_W-1:0] dvs;
      logic             valid_ff;
      rem_vec_type      rem_ff, rem_in;
      quot_vec_type     q_ff,   q_in;
      logic [ROOT_W-1:0] n_ff;
      tfn_side_type     side_ff;

      // compare and subtract the shifted divisor in each lane
      always_comb begin
         dvs  = DIV_W'(st_n[k]) << BIT;
         q_in = st_q[k];
         for (int i = 0; i < 3; i++) begin
            if (st_rem[k][i] >= dvs) begin
               rem_in[i]     = st_rem[k][i] - dvs;
               q_in[i][BIT]  = 1'b1;
            end else begin
               rem_in[i]     = st_rem[k][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= st_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            q_ff    <= q_in;
            n_ff    <= st_n[k];
            side_ff <= st_side[k];
         end
      end

      assign st_valid[k+1] = valid_ff;
      assign st_rem[k+1]   = rem_ff;
      assign st_q[k+1]     = q_ff;
      assign st_n[k+1]     = n_ff;
      assign st_side[k+1]  = side_ff;
   end

   assign out_valid = st_valid[QUOT_W];
   assign out_quot  = st_q[QUOT_W];
   assign out_side  = st_side[QUOT_W];

endmodule

// ----- src/tfn_unit.sv -----
// tfn_unit: normalises a three-component vector: block alignment, sum of
// squares, square root, per-lane division. Depends on tfn_pkg, tfn_isqrt, tfn_div.
module tfn_unit import tfn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         narrow,
   input  logic         in_valid,
   input  logic         in_tag,
   input  vec_type      in_vec,
   output logic         out_valid,
   output logic         out_tag,
   output logic         out_zero,
   output unit_vec_type out_vec
);

   // stage 1: magnitudes and their OR
   logic           s1_valid_ff;
   logic           s1_tag_ff;
   logic [2:0]     s1_neg_ff, s1_neg_in;
   vec_type        s1_mag_ff, s1_mag_in;
   logic [VEC_W-1:0] s1_or_ff, s1_or_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_neg_in[i] = in_vec[i][VEC_W-1];
         s1_mag_in[i] = s1_neg_in[i] ? (VEC_W'(0) - in_vec[i]) : in_vec[i];
      end
      s1_or_in = s1_mag_in[0] | s1_mag_in[1] | s1_mag_in[2];
   end

   // stage 2: leading one within each 16-bit chunk
   logic           s2_valid_ff;
   logic           s2_tag_ff;
   logic [2:0]     s2_neg_ff;
   vec_type        s2_mag_ff;
   logic [3:0]     s2_any_ff, s2_any_in;
   logic [3:0][3:0] s2_pos_ff, s2_pos_in;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         s2_any_in[c] = |s1_or_ff[16*c +: 16];
         s2_pos_in[c] = '0;
         for (int b = 0; b < 16; b++) begin
            if (s1_or_ff[16*c + b]) s2_pos_in[c] = 4'(b);
         end
      end
   end

   // stage 3: leading one over the word
   logic             s3_valid_ff;
   logic             s3_tag_ff;
   logic [2:0]       s3_neg_ff;
   vec_type          s3_mag_ff;
   logic [POS_W-1:0] s3_lead_ff, s3_lead_in;
   logic             s3_zero_ff, s3_zero_in;

   always_comb begin
      s3_lead_in = '0;
      for (int c = 0; c < 4; c++) begin
         if (s2_any_ff[c]) s3_lead_in = {2'(c), s2_pos_ff[c]};
      end
      s3_zero_in = ~|s2_any_ff;
   end

   // stage 4: common shift puts the largest magnitude at the alignment bit
   logic                  s4_valid_ff;
   tfn_side_type          s4_side_ff, s4_side_in;

   always_comb begin
      s4_side_in.tag  = s3_tag_ff;
      s4_side_in.zero = s3_zero_ff;
      s4_side_in.neg  = s3_neg_ff;
      for (int i = 0; i < 3; i++) begin
         if (s3_lead_ff >= POS_W'(ALIGN_LO)) begin
            s4_side_in.mag[i] =
               MAG_W'(s3_mag_ff[i] >> (s3_lead_ff - POS_W'(ALIGN_LO)));
         end else begin
            s4_side_in.mag[i] =
               MAG_W'(s3_mag_ff[i] << (POS_W'(ALIGN_LO) - s3_lead_ff));
         end
      end
   end

   // stage 5: squares
   logic                  s5_valid_ff;
   tfn_side_type          s5_side_ff;
   logic [2:0][SQ_W-1:0]  s5_sq_ff, s5_sq_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_sq_in[i] = SQ_W'(s4_side_ff.mag[i]) * SQ_W'(s4_side_ff.mag[i]);
      end
   end

   // stage 6: sum of squares
   logic             s6_valid_ff;
   tfn_side_type     s6_side_ff;
   logic [SUM_W-1:0] s6_sum_ff, s6_sum_in;

   assign s6_sum_in = SUM_W'(s5_sq_ff[0]) + SUM_W'(s5_sq_ff[1]) + SUM_W'(s5_sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff  <= in_tag;
         s1_neg_ff  <= s1_neg_in;
         s1_mag_ff  <= s1_mag_in;
         s1_or_ff   <= s1_or_in;
         s2_tag_ff  <= s1_tag_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_mag_ff  <= s1_mag_ff;
         s2_any_ff  <= s2_any_in;
         s2_pos_ff  <= s2_pos_in;
         s3_tag_ff  <= s2_tag_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_mag_ff  <= s2_mag_ff;
         s3_lead_ff <= s3_lead_in;
         s3_zero_ff <= s3_zero_in;
         s4_side_ff <= s4_side_in;
         s5_side_ff <= s4_side_ff;
         s5_sq_ff   <= s5_sq_in;
         s6_side_ff <= s5_side_ff;
         s6_sum_ff  <= s6_sum_in;
      end
   end

   // square root and division
   logic              rt_valid;
   logic [ROOT_W-1:0] rt_root;
   tfn_side_type      rt_side;
   logic              dv_valid;
   quot_vec_type      dv_quot;
   tfn_side_type      dv_side;

   tfn_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_valid_ff),
      .in_sum    (s6_sum_ff),
      .in_side   (s6_side_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   tfn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .narrow    (narrow),
      .in_valid  (rt_valid),
      .in_root   (rt_root),
      .in_side   (rt_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   // final stage: restore signs
   logic         fin_valid_ff;
   logic         fin_tag_ff;
   logic         fin_zero_ff;
   unit_vec_type fin_vec_ff, fin_vec_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fin_vec_in[i] = dv_side.neg[i] ? (COMP_W'(0) - COMP_W'(dv_quot[i]))
                                        : COMP_W'(dv_quot[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_tag_ff  <= dv_side.tag;
         fin_zero_ff <= dv_side.zero;
         fin_vec_ff  <= fin_vec_in;
      end
   end

   assign out_valid = fin_valid_ff;
   assign out_tag   = fin_tag_ff;
   assign out_zero  = fin_zero_ff;
   assign out_vec   = fin_vec_ff;

endmodule

// ----- src/tfn_cross.sv -----
// tfn_cross: two-stage cross product of two signed unit vectors.
// Depends on tfn_pkg.
module tfn_cross import tfn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic         in_tag,
   input  unit_vec_type in_a,
   input  unit_vec_type in_b,
   output logic         out_valid,
   output logic         out_tag,
   output vec_type      out_vec
);

   // stage 1: six signed products
   logic                     p_valid_ff;
   logic                     p_tag_ff;
   logic signed [VEC_W-1:0]  p_ff [0:5];
   logic signed [VEC_W-1:0]  p_in [0:5];

   always_comb begin
      p_in[0] = VEC_W'($signed(in_a[1]) * $signed(in_b[2]));
      p_in[1] = VEC_W'($signed(in_a[2]) * $signed(in_b[1]));
      p_in[2] = VEC_W'($signed(in_a[2]) * $signed(in_b[0]));
      p_in[3] = VEC_W'($signed(in_a[0]) * $signed(in_b[2]));
      p_in[4] = VEC_W'($signed(in_a[0]) * $signed(in_b[1]));
      p_in[5] = VEC_W'($signed(in_a[1]) * $signed(in_b[0]));
   end

   // stage 2: differences
   logic    c_valid_ff;
   logic    c_tag_ff;
   vec_type c_ff, c_in;

   always_comb begin
      c_in[0] = p_ff[0] - p_ff[1];
      c_in[1] = p_ff[2] - p_ff[3];
      c_in[2] = p_ff[4] - p_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= in_valid;
         c_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_tag_ff <= in_tag;
         for (int i = 0; i < 6; i++) p_ff[i] <= p_in[i];
         c_tag_ff <= p_tag_ff;
         c_ff     <= c_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_tag   = c_tag_ff;
   assign out_vec   = c_ff;

endmodule

// ----- src/triangle_face_normal.sv -----
// triangle_face_normal: unit face normal of one triangle per item.
// Depends on tfn_pkg, tfn_if, tfn_unit, tfn_cross.
//
// Usage: req_ch carries one triangle per item, three vertices in signed
// fixed point. rsp_ch returns one item per triangle: the unit normal in
// signed Q1.14 and a degenerate flag, set (with a zero normal) when an edge
// has zero length or the cross product of the unit edges is zero.
// Items leave in the order they arrive.
// From acceptance to the result on rsp_ch a triangle passes one edge
// stage, two 70-stage normalise units (alignment, squares, a 31-stage root,
// a three-lane divider) around a two-stage cross product, and the output
// register. Every stage is a register step.
// Throughput: one triangle per cycle unless rsp_ch stalls.
// Reset clears all valid bits; the pipeline comes out empty.
// When rsp_ch stalls while a result is waiting, the whole pipeline holds
// and req_ch.ready drops; nothing is lost or repeated.
module triangle_face_normal import tfn_pkg::*; (
   input logic      clock,
   input logic      reset,
   tfn_req_if.sink  req_ch,
   tfn_rsp_if.source rsp_ch
);

   logic en;
   logic out_valid_ff;

   // the pipeline advances whenever the output register can move
   assign en           = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // edge stage
   logic    e_valid_ff;
   vec_type e1_ff, e1_in, e2_ff, e2_in;
   logic [EDGE_W-1:0] d1 [0:2];
   logic [EDGE_W-1:0] d2 [0:2];

   always_comb begin
      d1[0] = {req_ch.second_x[COORD_WIDTH-1], req_ch.second_x}
            - {req_ch.first_x[COORD_WIDTH-1],  req_ch.first_x};
      d1[1] = {req_ch.second_y[COORD_WIDTH-1], req_ch.second_y}
            - {req_ch.first_y[COORD_WIDTH-1],  req_ch.first_y};
      d1[2] = {req_ch.second_z[COORD_WIDTH-1], req_ch.second_z}
            - {req_ch.first_z[COORD_WIDTH-1],  req_ch.first_z};
      d2[0] = {req_ch.third_x[COORD_WIDTH-1], req_ch.third_x}
            - {req_ch.first_x[COORD_WIDTH-1], req_ch.first_x};
      d2[1] = {req_ch.third_y[COORD_WIDTH-1], req_ch.third_y}
            - {req_ch.first_y[COORD_WIDTH-1], req_ch.first_y};
      d2[2] = {req_ch.third_z[COORD_WIDTH-1], req_ch.third_z}
            - {req_ch.first_z[COORD_WIDTH-1], req_ch.first_z};
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = {{(VEC_W-EDGE_W){d1[i][EDGE_W-1]}}, d1[i]};
         e2_in[i] = {{(VEC_W-EDGE_W){d2[i][EDGE_W-1]}}, d2[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
      end
   end

   // normalise both edges
   logic         u1_valid, u1_tag, u1_zero;
   logic         u2_valid, u2_tag, u2_zero;
   unit_vec_type u1_vec, u2_vec;

   tfn_unit u_edge1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .narrow    (1'b0),
      .in_valid  (e_valid_ff),
      .in_tag    (1'b0),
      .in_vec    (e1_ff),
      .out_valid (u1_valid),
      .out_tag   (u1_tag),
      .out_zero  (u1_zero),
      .out_vec   (u1_vec)
   );

   tfn_unit u_edge2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .narrow    (1'b0),
      .in_valid  (e_valid_ff),
      .in_tag    (1'b0),
      .in_vec    (e2_ff),
      .out_valid (u2_valid),
      .out_tag   (u2_tag),
      .out_zero  (u2_zero),
      .out_vec   (u2_vec)
   );

   // cross product; the zero-edge mark rides along as the tag
   logic    cr_valid, cr_tag;
   vec_type cr_vec;

   tfn_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (u1_valid & u2_valid),
      .in_tag    (u1_zero | u2_zero | u1_tag | u2_tag),
      .in_a      (u1_vec),
      .in_b      (u2_vec),
      .out_valid (cr_valid),
      .out_tag   (cr_tag),
      .out_vec   (cr_vec)
   );

   // normalise the cross product to the output format
   logic         n_valid, n_tag, n_zero;
   unit_vec_type n_vec;

   tfn_unit u_normal (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .narrow    (1'b1),
      .in_valid  (cr_valid),
      .in_tag    (cr_tag),
      .in_vec    (cr_vec),
      .out_valid (n_valid),
      .out_tag   (n_tag),
      .out_zero  (n_zero),
      .out_vec   (n_vec)
   );

   // output register
   logic             degen;
   logic [OUT_W-1:0] nx_ff, ny_ff, nz_ff;
   logic             degen_ff;

   assign degen = n_tag | n_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= n_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff    <= degen ? '0 : n_vec[0][OUT_W-1:0];
         ny_ff    <= degen ? '0 : n_vec[1][OUT_W-1:0];
         nz_ff    <= degen ? '0 : n_vec[2][OUT_W-1:0];
         degen_ff <= degen;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.normal_x   = nx_ff;
   assign rsp_ch.normal_y   = ny_ff;
   assign rsp_ch.normal_z   = nz_ff;
   assign rsp_ch.degenerate = degen_ff;

endmodule
